// ===== design/dtd_pkg.sv =====
// Shared types, character codes and constants for the coordinate text parser.
`timescale 1ns / 1ps

package dtd_pkg;

  // Magnitudes never exceed 2^39-1, so 39 bits hold them; the result is 40 bits signed.
  localparam int MAG_W = 39;
  localparam int DEG_W = 40;
  localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};

  // Character codes the parser reacts to.
  localparam logic [15:0] CH_DIGIT0 = 16'd48;
  localparam logic [15:0] CH_DIGIT9 = 16'd57;
  localparam logic [15:0] CH_DOT    = 16'd46;
  localparam logic [15:0] CH_DEGREE = 16'd176;
  localparam logic [15:0] CH_APOS   = 16'd39;
  localparam logic [15:0] CH_QUOTE  = 16'd34;
  localparam logic [15:0] CH_SOUTH  = 16'd83;
  localparam logic [15:0] CH_WEST   = 16'd87;
  localparam logic [15:0] CH_MINUS  = 16'd45;

  // Reciprocal division: q = floor(x * RECIP / 2^RECIP_SHIFT) is low by at most one.
  localparam int RECIP_SHIFT = 40;
  localparam int RECIP_W     = 35;
  localparam logic [63:0] RECIP_60_FULL   = (64'd1 << RECIP_SHIFT) / 64'd60;
  localparam logic [63:0] RECIP_3600_FULL = (64'd1 << RECIP_SHIFT) / 64'd3600;
  localparam logic [RECIP_W-1:0] RECIP_60   = RECIP_60_FULL[RECIP_W-1:0];
  localparam logic [RECIP_W-1:0] RECIP_3600 = RECIP_3600_FULL[RECIP_W-1:0];
  localparam logic [11:0] DIV_60   = 12'd60;
  localparam logic [11:0] DIV_3600 = 12'd3600;

  // Width of the reciprocal quotient estimate: x * RECIP < 2^74.
  localparam int QEST_W = 34;

  // Kind of mark that closes a number.
  typedef enum logic [1:0] {
    MARK_NONE,
    MARK_DEG,
    MARK_MIN,
    MARK_SEC
  } mark_t;

  // One character's worth of work as it travels down the pipeline.
  typedef struct packed {
    mark_t            kind;
    logic [MAG_W-1:0] mark_val;
    logic [MAG_W-1:0] cur;
    logic             neg;
    logic             last;
  } item_t;

  // Powers of ten up to 10^9.
  function automatic logic [29:0] pow10(input logic [3:0] e);
    logic [29:0] p;
    case (e)
      4'd0:    p = 30'd1;
      4'd1:    p = 30'd10;
      4'd2:    p = 30'd100;
      4'd3:    p = 30'd1000;
      4'd4:    p = 30'd10000;
      4'd5:    p = 30'd100000;
      4'd6:    p = 30'd1000000;
      4'd7:    p = 30'd10000000;
      4'd8:    p = 30'd100000000;
      4'd9:    p = 30'd1000000000;
      default: p = 30'd1;
    endcase
    return p;
  endfunction

endpackage

// ===== design/dtd_if.sv =====
// Valid/ready channel interfaces for character items and result items.
`timescale 1ns / 1ps

interface dtd_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] char_code;
  logic        last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface dtd_out_if;
  logic               valid;
  logic               ready;
  logic signed [39:0] degrees;

  modport source (output valid, output degrees, input ready);
  modport sink   (input valid, input degrees, output ready);
endinterface

// ===== design/dms_text_to_degrees_top.sv =====
// Coordinate text parser: characters in, signed fixed-point degrees out.
// A final character moves through stages s0 to s4; its result is then registered.
// One character per cycle unless the output stalls; a stage waits only on the next.
// Reset (rst_n low, synchronous) empties the pipeline and clears the string state.
`timescale 1ns / 1ps

module dms_text_to_degrees_top
  import dtd_pkg::*;
#(
  parameter int FRAC_DIGITS = 7
) (
  input  logic      clk,
  input  logic      rst_n,
  dtd_in_if.sink    in_if,
  dtd_out_if.source out_if
);

  localparam logic [3:0]  FRAC_LIM = 4'(FRAC_DIGITS);
  localparam logic [29:0] UNIT     = pow10(FRAC_LIM);

  // Pipeline valid flags and payload.
  logic             s0_v_r, s1_v_r, s2_v_r, s3_v_r, s4_v_r, out_v_r;
  logic [15:0]      s0_char_r;
  logic             s0_last_r;
  item_t            s1_r, s2_r, s3_r, s4_r;
  logic [RECIP_W-1:0] s1_recip;
  logic [37:0]      pp_ll_r;
  logic [36:0]      pp_lh_r, pp_hl_r;
  logic [35:0]      pp_hh_r;
  logic [QEST_W-1:0] qest_r;
  logic [MAG_W-1:0] q_r;
  logic signed [DEG_W-1:0] out_deg_r;

  // String state.
  logic [MAG_W-1:0] cur_r, cur_nxt;
  logic [3:0]       fpos_r, fpos_nxt;
  logic             infrac_r, infrac_nxt;
  logic             neg_r, neg_nxt;
  logic [MAG_W-1:0] sum_r, sum_nxt;

  logic out_free, mv0, mv1, mv2, mv3, mv4;

  // Each stage moves on when the next one is empty or moving itself.
  assign out_free = !out_v_r || out_if.ready;
  assign mv4 = s4_v_r && (!s4_r.last || out_free);
  assign mv3 = s3_v_r && (!s4_v_r || mv4);
  assign mv2 = s2_v_r && (!s3_v_r || mv3);
  assign mv1 = s1_v_r && (!s2_v_r || mv2);
  assign mv0 = s0_v_r && (!s1_v_r || mv1);
  assign in_if.ready = !s0_v_r || mv0;

  assign out_if.valid   = out_v_r;
  assign out_if.degrees = out_deg_r;

  // Character decode and update of the current number.
  logic             is_digit;
  logic [3:0]       digit;
  logic [3:0]       fpos_inc;
  logic [42:0]      cur_x10;
  logic [33:0]      int_add, frac_add;
  logic [43:0]      dig_sum;
  logic [MAG_W-1:0] dig_val;
  mark_t            kind;
  item_t            s1_nxt;

  always_comb begin
    is_digit = s0_char_r inside {[CH_DIGIT0:CH_DIGIT9]};
    digit    = 4'(s0_char_r - CH_DIGIT0);
    fpos_inc = fpos_r + 4'd1;
    cur_x10  = ({4'd0, cur_r} << 3) + ({4'd0, cur_r} << 1);
    int_add  = 34'(UNIT * digit);
    frac_add = 34'(pow10(FRAC_LIM - fpos_inc) * digit);
    if (infrac_r) begin
      dig_sum = {5'd0, cur_r} + {10'd0, frac_add};
    end else begin
      dig_sum = {1'b0, cur_x10} + {10'd0, int_add};
    end
    dig_val = (dig_sum > {5'd0, MAG_MAX}) ? MAG_MAX : dig_sum[MAG_W-1:0];

    case (s0_char_r)
      CH_DEGREE: kind = MARK_DEG;
      CH_APOS:   kind = MARK_MIN;
      CH_QUOTE:  kind = MARK_SEC;
      default:   kind = MARK_NONE;
    endcase

    cur_nxt    = cur_r;
    fpos_nxt   = fpos_r;
    infrac_nxt = infrac_r;
    neg_nxt    = neg_r || (s0_char_r == CH_SOUTH) || (s0_char_r == CH_WEST) ||
                 (s0_char_r == CH_MINUS);
    if (is_digit) begin
      if (!infrac_r) begin
        cur_nxt = dig_val;
      end else if (fpos_r < FRAC_LIM) begin
        cur_nxt  = dig_val;
        fpos_nxt = fpos_inc;
      end
    end else if (s0_char_r == CH_DOT) begin
      fpos_nxt   = 4'd0;
      infrac_nxt = 1'b1;
    end else if (kind != MARK_NONE) begin
      cur_nxt    = '0;
      infrac_nxt = 1'b0;
    end

    s1_nxt.kind     = kind;
    s1_nxt.mark_val = cur_r;
    s1_nxt.cur      = cur_nxt;
    s1_nxt.neg      = neg_nxt;
    s1_nxt.last     = s0_last_r;
  end

  // Reciprocal for the minutes or seconds divide.
  assign s1_recip = (s1_r.kind == MARK_SEC) ? RECIP_3600 : RECIP_60;

  // Quotient correction: the estimate is low by at most one.
  logic [11:0]      div_k;
  logic [45:0]      qd;
  logic [MAG_W:0]   rem;
  logic [MAG_W-1:0] q_nxt;
  logic [73:0]      prod_sum;

  always_comb begin
    prod_sum = {36'd0, pp_ll_r} + ({37'd0, pp_lh_r} << 18) + ({37'd0, pp_hl_r} << 20) +
               ({38'd0, pp_hh_r} << 38);
    div_k = (s3_r.kind == MARK_SEC) ? DIV_3600 : DIV_60;
    qd    = 46'(qest_r * div_k);
    rem   = {1'b0, s3_r.mark_val} - qd[MAG_W:0];
    case (s3_r.kind)
      MARK_DEG:          q_nxt = s3_r.mark_val;
      MARK_MIN, MARK_SEC: begin
        q_nxt = MAG_W'(qest_r) + ((rem >= {28'd0, div_k}) ? 39'd1 : 39'd0);
      end
      default:           q_nxt = '0;
    endcase
  end

  // Saturating accumulation and the end-of-string result.
  logic [MAG_W:0]   acc;
  logic [MAG_W-1:0] acc_sat;
  logic [MAG_W-1:0] mag;
  logic [DEG_W-1:0] mag_ext;

  always_comb begin
    acc     = {1'b0, sum_r} + {1'b0, q_r};
    acc_sat = acc[MAG_W] ? MAG_MAX : acc[MAG_W-1:0];
    mag     = (acc_sat == '0) ? s4_r.cur : acc_sat;
    mag_ext = {1'b0, mag};
    sum_nxt = s4_r.last ? '0 : acc_sat;
  end

  // Control state: valid flags and the string state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r   <= 1'b0;
      s1_v_r   <= 1'b0;
      s2_v_r   <= 1'b0;
      s3_v_r   <= 1'b0;
      s4_v_r   <= 1'b0;
      out_v_r  <= 1'b0;
      cur_r    <= '0;
      fpos_r   <= '0;
      infrac_r <= 1'b0;
      neg_r    <= 1'b0;
      sum_r    <= '0;
    end else begin
      if (in_if.ready) s0_v_r <= in_if.valid;
      if (!s1_v_r || mv1) s1_v_r <= mv0;
      if (!s2_v_r || mv2) s2_v_r <= mv1;
      if (!s3_v_r || mv3) s3_v_r <= mv2;
      if (!s4_v_r || mv4) s4_v_r <= mv3;
      if (out_free) out_v_r <= mv4 && s4_r.last;
      if (mv0) begin
        if (s0_last_r) begin
          cur_r    <= '0;
          fpos_r   <= '0;
          infrac_r <= 1'b0;
          neg_r    <= 1'b0;
        end else begin
          cur_r    <= cur_nxt;
          fpos_r   <= fpos_nxt;
          infrac_r <= infrac_nxt;
          neg_r    <= neg_nxt;
        end
      end
      if (mv4) sum_r <= sum_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_if.ready) begin
      s0_char_r <= in_if.char_code;
      s0_last_r <= in_if.last_char;
    end
    if (mv0) s1_r <= s1_nxt;
    if (mv1) begin
      s2_r    <= s1_r;
      pp_ll_r <= 38'(s1_r.mark_val[19:0] * s1_recip[17:0]);
      pp_lh_r <= 37'(s1_r.mark_val[19:0] * s1_recip[34:18]);
      pp_hl_r <= 37'(s1_r.mark_val[38:20] * s1_recip[17:0]);
      pp_hh_r <= 36'(s1_r.mark_val[38:20] * s1_recip[34:18]);
    end
    if (mv2) begin
      s3_r   <= s2_r;
      qest_r <= prod_sum[73:RECIP_SHIFT];
    end
    if (mv3) begin
      s4_r <= s3_r;
      q_r  <= q_nxt;
    end
    if (mv4 && s4_r.last) begin
      out_deg_r <= s4_r.neg ? -$signed(mag_ext) : $signed(mag_ext);
    end
  end

endmodule

// ===== design/dtd_checker.sv =====
// Port-level checks for the coordinate text parser, bound to the top level.
`timescale 1ns / 1ps

module dtd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_last,
  input logic        out_valid,
  input logic        out_ready,
  input logic [39:0] out_degrees
);

  // Final characters accepted whose results have not yet been taken.
  logic [2:0] pending_r;
  logic       in_end, out_acc;

  assign in_end  = in_valid && in_ready && in_last;
  assign out_acc = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else begin
      pending_r <= pending_r + {2'd0, in_end} - {2'd0, out_acc};
    end
  end

  // A result that waits keeps being offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result item withdrawn before it was taken");

  // Every result belongs to a final character taken earlier.
  a_out_owed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pending_r != 3'd0)
    else $error("result item without a final character");

  // No more strings in flight than the pipeline has stages.
  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r <= 3'd6)
    else $error("too many strings in flight");

  // Magnitudes are saturated, so the most negative code never appears.
  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_degrees != 40'h80_0000_0000)
    else $error("result magnitude beyond saturation");

endmodule

bind dms_text_to_degrees_top dtd_checker u_dtd_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_if.valid),
  .in_ready    (in_if.ready),
  .in_last     (in_if.last_char),
  .out_valid   (out_if.valid),
  .out_ready   (out_if.ready),
  .out_degrees (out_if.degrees)
);

// ===== dv/tb.sv =====
// Self-checking testbench for the coordinate text parser, with its own model of the parsing rules.
`timescale 1ns / 1ps

module tb
  import dtd_pkg::*;
();

  localparam int FRAC_DIGITS = 7;
  localparam int RESET_CYCLES = 10;
  localparam int PIPE_LATENCY = 5;
  localparam int DRAIN_CYCLES = 4 * PIPE_LATENCY;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 2000;
  localparam logic [63:0] MAG_CEIL = (64'd1 << 39) - 64'd1;
  localparam logic [63:0] MINUTES_PER_DEGREE = 64'd60;
  localparam logic [63:0] SECONDS_PER_DEGREE = 64'd3600;

  // Characters the parser ignores but which appear in real coordinate text.
  localparam logic [15:0] CH_NORTH = 16'd78;
  localparam logic [15:0] CH_EAST = 16'd69;
  localparam logic [15:0] CH_SPACE = 16'd32;

  typedef logic [15:0] char_t;
  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_RANDOM,
    RX_PATTERN
  } rx_mode_t;

  logic clk = 1'b0;
  logic rst_n;

  dtd_in_if  in_ch ();
  dtd_out_if out_ch ();

  dms_text_to_degrees_top #(
    .FRAC_DIGITS(FRAC_DIGITS)
  ) DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_ch),
    .out_if(out_ch)
  );

  always #5 clk = ~clk;

  // Model state for the string being parsed.
  logic [63:0] text_sum;
  logic [63:0] number_value;
  int unsigned decimals_taken;
  bit          in_decimals;
  bit          sign_seen;

  logic [DEG_W-1:0] expected_degrees[$];

  int       mismatches = 0;
  int       chars_sent = 0;
  int       idle_cycles = 0;
  int       holds_asked = 0;
  rx_mode_t rx_mode;
  bit       tx_gaps_on = 1'b1;
  int       burst_left = 1;

  function automatic logic [63:0] ten_pow(input int e);
    logic [63:0] p;
    int k;
    p = 64'd1;
    for (k = 0; k < e; k++) p = p * 64'd10;
    return p;
  endfunction

  function automatic logic [63:0] clamp_add(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    return (s > MAG_CEIL) ? MAG_CEIL : s;
  endfunction

  function automatic void clear_text_state();
    text_sum = '0;
    number_value = '0;
    decimals_taken = 0;
    in_decimals = 1'b0;
    sign_seen = 1'b0;
  endfunction

  // A mark folds the current number into the sum, scaled down by its divisor.
  function automatic void close_number(input logic [63:0] divisor);
    text_sum = clamp_add(text_sum, number_value / divisor);
    number_value = '0;
    in_decimals = 1'b0;
  endfunction

  function automatic char_t digit_char(input int d);
    return CH_DIGIT0 + char_t'(d);
  endfunction

  // Advance the model by one accepted character; the final one yields the expected degrees.
  task automatic parse_char(input char_t c, input logic last);
    logic [63:0] d;
    logic [63:0] mag;
    logic [DEG_W-1:0] v;
    if (c == CH_SOUTH || c == CH_WEST || c == CH_MINUS) sign_seen = 1'b1;
    if (c >= CH_DIGIT0 && c <= CH_DIGIT9) begin
      d = 64'(c - CH_DIGIT0);
      if (in_decimals) begin
        if (decimals_taken < FRAC_DIGITS) begin
          decimals_taken++;
          number_value = clamp_add(number_value, d * ten_pow(FRAC_DIGITS - decimals_taken));
        end
      end else begin
        number_value = clamp_add(number_value * 64'd10, d * ten_pow(FRAC_DIGITS));
      end
    end else if (c == CH_DOT) begin
      decimals_taken = 0;
      in_decimals = 1'b1;
    end else if (c == CH_DEGREE) begin
      close_number(64'd1);
    end else if (c == CH_APOS) begin
      close_number(MINUTES_PER_DEGREE);
    end else if (c == CH_QUOTE) begin
      close_number(SECONDS_PER_DEGREE);
    end
    if (last) begin
      mag = (text_sum == 0) ? number_value : text_sum;
      v = mag[DEG_W-1:0];
      if (sign_seen) v = -v;
      expected_degrees.push_back(v);
      clear_text_state();
    end
  endtask

  // Offer one item, wait for the handshake, then possibly pause before the next burst.
  task automatic send_char(input char_t c, input logic last);
    int gap;
    in_ch.valid <= 1'b1;
    in_ch.char_code <= c;
    in_ch.last_char <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    parse_char(c, last);
    chars_sent++;
    if (tx_gaps_on) begin
      burst_left--;
      if (burst_left <= 0) begin
        gap = $urandom_range(1, 6);
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
        burst_left = $urandom_range(1, 16);
      end
    end
  endtask

  task automatic send_text(ref char_t s[$]);
    int k;
    for (k = 0; k < s.size(); k++) send_char(s[k], k == s.size() - 1);
  endtask

  // Integer digits, sometimes a long run to push into saturation, and maybe a fraction.
  task automatic append_number(ref char_t s[$], input int max_digits);
    int n;
    int k;
    bit nines;
    nines = ($urandom_range(0, 1) != 0);
    if ($urandom_range(0, 9) == 0) begin
      n = $urandom_range(5, 14);
      for (k = 0; k < n; k++) s.push_back(nines ? digit_char(9) : digit_char($urandom_range(0, 9)));
    end else begin
      n = $urandom_range(0, max_digits);
      for (k = 0; k < n; k++) s.push_back(digit_char($urandom_range(0, 9)));
    end
    if ($urandom_range(0, 2) == 0) begin
      s.push_back(CH_DOT);
      n = $urandom_range(0, 9);
      for (k = 0; k < n; k++) s.push_back(digit_char($urandom_range(0, 9)));
    end
  endtask

  // A well-formed coordinate: optional sign, degrees, then optional minutes, seconds and hemisphere.
  task automatic build_coordinate(ref char_t s[$]);
    s.delete();
    if ($urandom_range(0, 3) == 0) s.push_back(CH_MINUS);
    append_number(s, 3);
    if ($urandom_range(0, 5) != 0) begin
      s.push_back(CH_DEGREE);
      if ($urandom_range(0, 4) != 0) begin
        append_number(s, 2);
        s.push_back(CH_APOS);
        if ($urandom_range(0, 3) != 0) begin
          append_number(s, 2);
          s.push_back(CH_QUOTE);
        end
      end
      if ($urandom_range(0, 3) == 0) s.push_back(CH_SPACE);
      case ($urandom_range(0, 4))
        0: s.push_back(CH_SOUTH);
        1: s.push_back(CH_WEST);
        2: s.push_back(CH_NORTH);
        3: s.push_back(CH_EAST);
        default: ;
      endcase
    end
    if (s.size() == 0) s.push_back(digit_char($urandom_range(0, 9)));
  endtask

  // Arbitrary characters, weighted towards the ones the parser reacts to.
  task automatic build_noise(ref char_t s[$]);
    int n;
    int k;
    s.delete();
    n = $urandom_range(1, 12);
    for (k = 0; k < n; k++) begin
      case ($urandom_range(0, 3))
        0: s.push_back(char_t'($urandom_range(0, 65535)));
        1: s.push_back(digit_char($urandom_range(0, 9)));
        2: begin
          case ($urandom_range(0, 8))
            0: s.push_back(CH_DOT);
            1: s.push_back(CH_DEGREE);
            2: s.push_back(CH_APOS);
            3: s.push_back(CH_QUOTE);
            4: s.push_back(CH_SOUTH);
            5: s.push_back(CH_WEST);
            6: s.push_back(CH_MINUS);
            7: s.push_back(CH_NORTH);
            default: s.push_back(CH_SPACE);
          endcase
        end
        default: s.push_back(char_t'($urandom_range(0, 255)));
      endcase
    end
  endtask

  task automatic test_directed_strings();
    char_t s[$];
    int k;
    rx_mode <= RX_PATTERN;
    tx_gaps_on = 1'b1;
    // An ignored top code ahead of a lone digit.
    s = {char_t'(16'hFFFF), digit_char(5)};
    send_text(s);
    // Full degrees, minutes and seconds in the southern hemisphere.
    s = {digit_char(1), digit_char(2), CH_DEGREE, digit_char(3), digit_char(0), CH_APOS,
         digit_char(3), digit_char(6), CH_QUOTE, CH_SOUTH};
    send_text(s);
    // Minus sign, a mark with no number, then more fraction digits than are kept.
    s = {CH_MINUS, CH_DEGREE, CH_DOT};
    for (k = 1; k <= 8; k++) s.push_back(digit_char(k));
    s.push_back(char_t'(16'h0000));
    send_text(s);
  endtask

  task automatic test_random_coordinates();
    char_t s[$];
    int start;
    start = chars_sent;
    while (chars_sent - start < 700) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 2));
      tx_gaps_on = ($urandom_range(0, 3) != 0);
      build_coordinate(s);
      send_text(s);
    end
  endtask

  // The receiver holds off for a long stretch while single-digit strings keep coming.
  task automatic test_output_hold();
    int k;
    tx_gaps_on = 1'b0;
    rx_mode <= RX_ALWAYS;
    holds_asked <= holds_asked + 1;
    for (k = 0; k < 120; k++) send_char(digit_char($urandom_range(0, 9)), 1'b1);
  endtask

  task automatic test_noise_strings();
    char_t s[$];
    int start;
    start = chars_sent;
    while (chars_sent - start < 230) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 2));
      tx_gaps_on = ($urandom_range(0, 1) != 0);
      build_noise(s);
      send_text(s);
    end
  endtask

  // Receiver: ready follows the chosen mode, or is held low for a long stretch on request.
  initial begin : receiver
    int hold_left;
    int holds_done;
    logic [7:0] rx_pattern;
    hold_left = 0;
    holds_done = 0;
    rx_pattern = 8'b1101_0110;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      rx_pattern = {rx_pattern[0], rx_pattern[7:1]};
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (holds_done != holds_asked) begin
        holds_done++;
        hold_left = HOLD_CYCLES;
        out_ch.ready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_ALWAYS: out_ch.ready <= 1'b1;
          RX_RANDOM: out_ch.ready <= ($urandom_range(0, 9) < 6);
          default:   out_ch.ready <= rx_pattern[0];
        endcase
      end
    end
  end

  // Each accepted result item is checked against the oldest expected value.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_degrees.size() == 0) begin
        $display("%0t: unexpected result, actual %0d", $time, $signed(out_ch.degrees));
        mismatches <= mismatches + 1;
      end else if (out_ch.degrees !== expected_degrees[0]) begin
        $display("%0t: degrees mismatch, expected %0d actual %0d", $time,
                 $signed(expected_degrees[0]), $signed(out_ch.degrees));
        mismatches <= mismatches + 1;
        void'(expected_degrees.pop_front());
      end else begin
        void'(expected_degrees.pop_front());
      end
    end
  end

  // Watchdog on cycles in which neither channel moves an item.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    clear_text_state();
    in_ch.valid <= 1'b0;
    in_ch.char_code <= '0;
    in_ch.last_char <= 1'b0;
    rst_n <= 1'b0;
    rx_mode <= RX_ALWAYS;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_strings();
    test_random_coordinates();
    test_output_hold();
    test_noise_strings();
    in_ch.valid <= 1'b0;

    // Let every outstanding result arrive, then a little longer for strays.
    while (expected_degrees.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_degrees.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
